### hw/rtl/tlss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlss_pkg
// Types, constants and per-leg planning functions for the two-leg sweep
// trajectory sequencer.
// ----------------------------------------------------------------------------
package tlss_pkg;

   // angle format: signed Q3.13, pi = 25736
   localparam logic signed [17:0] PI_Q     = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;

   // commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // leg phases
   localparam logic [1:0] PH_PRESWEEP = 2'd0;
   localparam logic [1:0] PH_LENGTH   = 2'd1;
   localparam logic [1:0] PH_SWEEP    = 2'd2;
   localparam logic [1:0] PH_FINISHED = 2'd3;

   // register indexes
   localparam logic [2:0] REG_START_ANGLE      = 3'd0;
   localparam logic [2:0] REG_FINAL_ANGLE      = 3'd1;
   localparam logic [2:0] REG_JUMP_LENGTH      = 3'd2;
   localparam logic [2:0] REG_ANGLE_STEP       = 3'd3;
   localparam logic [2:0] REG_LENGTH_STEP      = 3'd4;
   localparam logic [2:0] REG_ANGLE_TOLERANCE  = 3'd5;
   localparam logic [2:0] REG_LENGTH_TOLERANCE = 3'd6;
   localparam logic [2:0] REG_SETTLE_TICKS     = 3'd7;

   // register reset values
   localparam logic signed [15:0] RST_START_ANGLE      = -16'sd23347;
   localparam logic signed [15:0] RST_FINAL_ANGLE      = 16'sd20234;
   localparam logic [15:0]        RST_JUMP_LENGTH      = 16'd11141;
   localparam logic [10:0]        RST_ANGLE_STEP       = 11'd32;
   localparam logic [10:0]        RST_LENGTH_STEP      = 11'd33;
   localparam logic [12:0]        RST_ANGLE_TOLERANCE  = 13'd410;
   localparam logic [13:0]        RST_LENGTH_TOLERANCE = 14'd655;
   localparam logic [15:0]        RST_SETTLE_TICKS     = 16'd100;

   typedef struct packed {
      logic signed [15:0] start_angle;
      logic signed [15:0] final_angle;
      logic [15:0]        jump_length;
      logic [10:0]        angle_step;
      logic [10:0]        length_step;
      logic [12:0]        angle_tolerance;
      logic [13:0]        length_tolerance;
      logic [15:0]        settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] goal_angle;
      logic [15:0]        goal_length;
      logic [1:0]         phase;
   } leg_type;

   typedef struct packed {
      logic signed [15:0] goal_angle_right;
      logic signed [15:0] goal_angle_left;
      logic [15:0]        goal_length_right;
      logic [15:0]        goal_length_left;
      logic signed [15:0] angle_error_right;
      logic signed [15:0] angle_error_left;
      logic [1:0]         phase_right;
      logic [1:0]         phase_left;
      logic               done_res;
   } rsp_type;

   // single wrap into +-pi
   function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
      logic signed [17:0] r;
      r = a;
      if (a > PI_Q) begin
         r = a - TWO_PI_Q;
      end else if (a < -PI_Q) begin
         r = a + TWO_PI_Q;
      end
      return r;
   endfunction

   // |a - b| < tol on signed angles
   function automatic logic angle_near(input logic signed [15:0] a,
                                       input logic signed [15:0] b,
                                       input logic [12:0] tol);
      logic signed [16:0] d;
      logic [16:0]        m;
      d = {a[15], a} - {b[15], b};
      m = d[16] ? 17'(-d) : 17'(d);
      return m < {4'b0, tol};
   endfunction

   // |a - b| < tol on unsigned lengths
   function automatic logic length_near(input logic [15:0] a,
                                        input logic [15:0] b,
                                        input logic [13:0] tol);
      logic signed [16:0] d;
      logic [16:0]        m;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      m = d[16] ? 17'(-d) : 17'(d);
      return m < {3'b0, tol};
   endfunction

   // wrapped target-minus-measured angle
   function automatic logic signed [15:0] angle_error(input logic signed [15:0] goal,
                                                      input logic signed [15:0] alpha);
      logic signed [17:0] d;
      logic signed [17:0] w;
      d = {{2{goal[15]}}, goal} - {{2{alpha[15]}}, alpha};
      w = wrap_once(d);
      return w[15:0];
   endfunction

   // one tick of the three-phase planner for one leg; phases fall through
   function automatic leg_type plan_leg(input leg_type st,
                                        input logic signed [15:0] alpha,
                                        input logic [15:0] len,
                                        input cfg_type cfg);
      leg_type            nx;
      logic signed [17:0] s;
      logic signed [17:0] w;
      logic [17:0]        up;
      logic signed [17:0] dn;
      nx = st;
      if (nx.phase == PH_PRESWEEP) begin
         if (angle_near(nx.goal_angle, cfg.start_angle, cfg.angle_tolerance)) begin
            nx.goal_angle = cfg.start_angle;
         end else begin
            s = {{2{nx.goal_angle[15]}}, nx.goal_angle} + $signed({7'b0, cfg.angle_step});
            w = wrap_once(s);
            nx.goal_angle = w[15:0];
         end
         if (angle_near(alpha, cfg.start_angle, cfg.angle_tolerance)) begin
            nx.phase = PH_LENGTH;
         end
      end
      if (nx.phase == PH_LENGTH) begin
         if (length_near(nx.goal_length, cfg.jump_length, cfg.length_tolerance)) begin
            nx.goal_length = cfg.jump_length;
         end else if (nx.goal_length < cfg.jump_length) begin
            up = {2'b0, nx.goal_length} + {7'b0, cfg.length_step};
            nx.goal_length = (up > 18'd65535) ? 16'hFFFF : up[15:0];
         end else if (nx.goal_length > cfg.jump_length) begin
            dn = $signed({2'b0, nx.goal_length}) - $signed({7'b0, cfg.length_step});
            nx.goal_length = dn[17] ? 16'd0 : dn[15:0];
         end
         if (length_near(len, cfg.jump_length, cfg.length_tolerance)) begin
            nx.phase = PH_SWEEP;
         end
      end
      if (nx.phase == PH_SWEEP) begin
         if (angle_near(nx.goal_angle, cfg.final_angle, cfg.angle_tolerance)) begin
            nx.goal_angle = cfg.final_angle;
         end else begin
            s = {{2{nx.goal_angle[15]}}, nx.goal_angle} - $signed({7'b0, cfg.angle_step});
            w = wrap_once(s);
            nx.goal_angle = w[15:0];
         end
         if (angle_near(alpha, cfg.final_angle, cfg.angle_tolerance)) begin
            nx.phase = PH_FINISHED;
         end
      end
      return nx;
   endfunction

endpackage

### hw/rtl/two_leg_sweep_trajectory_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_leg_sweep_trajectory_sequencer_core
// Per-leg three-phase sweep planner for two legs with settle/done tracking.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | cmd, measured angles, lengths
//   rsp     | out       | rsp_valid/rsp_ready | targets, errors, phases, done
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// One word per cycle while req_ready is high: the planner state updates in
// the cycle the request word is taken, and the response is registered.
// A two-deep output (register plus skid) keeps req_ready high while one
// response waits; req_ready drops only when the skid slot is full.
// Synchronous active-high reset restores the register defaults and clears
// targets, phases, settle count and done.
module two_leg_sweep_trajectory_sequencer_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [15:0] req_alpha_right,
   input  logic signed [15:0] req_alpha_left,
   input  logic [15:0]        req_length_right,
   input  logic [15:0]        req_length_left,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_goal_angle_right,
   output logic signed [15:0] rsp_goal_angle_left,
   output logic [15:0]        rsp_goal_length_right,
   output logic [15:0]        rsp_goal_length_left,
   output logic signed [15:0] rsp_angle_error_right,
   output logic signed [15:0] rsp_angle_error_left,
   output logic [1:0]         rsp_phase_right,
   output logic [1:0]         rsp_phase_left,
   output logic               rsp_done_res,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   tlss_pkg::cfg_type cfg_ff;
   tlss_pkg::leg_type leg_r_ff, leg_r_in;
   tlss_pkg::leg_type leg_l_ff, leg_l_in;
   logic [16:0]       settle_ff, settle_in;
   logic              done_ff, done_in;

   tlss_pkg::rsp_type out_ff, skid_ff, rsp_in;
   logic              out_valid_ff, skid_valid_ff;

   logic              accept;
   logic              pop;
   logic              all_near;
   logic [16:0]       settle_inc;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_angle      <= tlss_pkg::RST_START_ANGLE;
         cfg_ff.final_angle      <= tlss_pkg::RST_FINAL_ANGLE;
         cfg_ff.jump_length      <= tlss_pkg::RST_JUMP_LENGTH;
         cfg_ff.angle_step       <= tlss_pkg::RST_ANGLE_STEP;
         cfg_ff.length_step      <= tlss_pkg::RST_LENGTH_STEP;
         cfg_ff.angle_tolerance  <= tlss_pkg::RST_ANGLE_TOLERANCE;
         cfg_ff.length_tolerance <= tlss_pkg::RST_LENGTH_TOLERANCE;
         cfg_ff.settle_ticks     <= tlss_pkg::RST_SETTLE_TICKS;
      end else if (csr_we) begin
         case (csr_index)
            tlss_pkg::REG_START_ANGLE:      cfg_ff.start_angle      <= csr_wdata;
            tlss_pkg::REG_FINAL_ANGLE:      cfg_ff.final_angle      <= csr_wdata;
            tlss_pkg::REG_JUMP_LENGTH:      cfg_ff.jump_length      <= csr_wdata;
            tlss_pkg::REG_ANGLE_STEP:       cfg_ff.angle_step       <= csr_wdata[10:0];
            tlss_pkg::REG_LENGTH_STEP:      cfg_ff.length_step      <= csr_wdata[10:0];
            tlss_pkg::REG_ANGLE_TOLERANCE:  cfg_ff.angle_tolerance  <= csr_wdata[12:0];
            tlss_pkg::REG_LENGTH_TOLERANCE: cfg_ff.length_tolerance <= csr_wdata[13:0];
            tlss_pkg::REG_SETTLE_TICKS:     cfg_ff.settle_ticks     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- planner ----
   assign all_near =
      tlss_pkg::angle_near(req_alpha_right, cfg_ff.final_angle, cfg_ff.angle_tolerance) &&
      tlss_pkg::angle_near(req_alpha_left, cfg_ff.final_angle, cfg_ff.angle_tolerance) &&
      tlss_pkg::length_near(req_length_right, cfg_ff.jump_length, cfg_ff.length_tolerance) &&
      tlss_pkg::length_near(req_length_left, cfg_ff.jump_length, cfg_ff.length_tolerance);

   assign settle_inc = settle_ff + 17'd1;

   always_comb begin
      leg_r_in  = leg_r_ff;
      leg_l_in  = leg_l_ff;
      settle_in = settle_ff;
      done_in   = done_ff;
      if (req_cmd == tlss_pkg::CMD_START) begin
         leg_r_in.goal_angle  = req_alpha_right;
         leg_r_in.goal_length = req_length_right;
         leg_r_in.phase       = tlss_pkg::PH_PRESWEEP;
         leg_l_in.goal_angle  = req_alpha_left;
         leg_l_in.goal_length = req_length_left;
         leg_l_in.phase       = tlss_pkg::PH_PRESWEEP;
         settle_in            = '0;
         done_in              = 1'b0;
      end else begin
         leg_r_in = tlss_pkg::plan_leg(leg_r_ff, req_alpha_right, req_length_right, cfg_ff);
         leg_l_in = tlss_pkg::plan_leg(leg_l_ff, req_alpha_left, req_length_left, cfg_ff);
         if (all_near) begin
            // count is kept when the legs leave the window
            if (settle_inc > {1'b0, cfg_ff.settle_ticks}) begin
               settle_in = '0;
               done_in   = 1'b1;
            end else begin
               settle_in = settle_inc;
            end
         end
      end

      rsp_in.goal_angle_right  = leg_r_in.goal_angle;
      rsp_in.goal_angle_left   = leg_l_in.goal_angle;
      rsp_in.goal_length_right = leg_r_in.goal_length;
      rsp_in.goal_length_left  = leg_l_in.goal_length;
      rsp_in.angle_error_right = tlss_pkg::angle_error(leg_r_in.goal_angle, req_alpha_right);
      rsp_in.angle_error_left  = tlss_pkg::angle_error(leg_l_in.goal_angle, req_alpha_left);
      rsp_in.phase_right       = leg_r_in.phase;
      rsp_in.phase_left        = leg_l_in.phase;
      rsp_in.done_res          = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_r_ff  <= '0;
         leg_l_ff  <= '0;
         settle_ff <= '0;
         done_ff   <= 1'b0;
      end else if (accept) begin
         leg_r_ff  <= leg_r_in;
         leg_l_ff  <= leg_l_in;
         settle_ff <= settle_in;
         done_ff   <= done_in;
      end
   end

   // ---- output register with skid slot ----
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= rsp_in;
         end else begin
            skid_ff <= rsp_in;
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_goal_angle_right  = out_ff.goal_angle_right;
   assign rsp_goal_angle_left   = out_ff.goal_angle_left;
   assign rsp_goal_length_right = out_ff.goal_length_right;
   assign rsp_goal_length_left  = out_ff.goal_length_left;
   assign rsp_angle_error_right = out_ff.angle_error_right;
   assign rsp_angle_error_left  = out_ff.angle_error_left;
   assign rsp_phase_right       = out_ff.phase_right;
   assign rsp_phase_left        = out_ff.phase_left;
   assign rsp_done_res          = out_ff.done_res;

`ifndef SYNTH
   // skid slot only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // done stays latched until a start word
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff && !(accept && req_cmd == tlss_pkg::CMD_START) |=> done_ff)
      else $error("done dropped without start");

   // start clears phases, count and done
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == tlss_pkg::CMD_START |=>
         leg_r_ff.phase == tlss_pkg::PH_PRESWEEP &&
         leg_l_ff.phase == tlss_pkg::PH_PRESWEEP &&
         settle_ff == '0 && !done_ff)
      else $error("start did not clear planner state");
`endif

endmodule
